// File: rtl/spsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsn_pkg
// Shared types and binary32 arithmetic helpers for the spinor norm block.
// ----------------------------------------------------------------------------
package spsn_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] PINF = 32'h7F80_0000;

    // last step of a site-open request, of a site-closing one, and of a final one
    localparam logic [3:0] STEP_OPEN_END  = 4'd7;
    localparam logic [3:0] STEP_CLOSE_END = 4'd11;
    localparam logic [3:0] STEP_EMIT      = 4'd12;

    typedef struct packed {
        logic [2:0][31:0] re;
        logic [2:0][31:0] im;
        logic             close_site;
        logic             last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // Round value n * 2^x to binary32, round to nearest even, subnormals kept.
    function automatic logic [31:0] round_pack(input logic s, input logic [63:0] n,
                                               input int x);
        int          l;
        int          sh;
        int          fe;
        logic [63:0] q;
        logic [63:0] mask;
        logic        g;
        logic        st;
        l = 0;
        for (int i = 0; i < 64; i++) begin
            if (n[i]) l = i;
        end
        if (n == 64'd0) return {s, 31'd0};
        sh = l - 23;
        if (sh < -149 - x) sh = -149 - x;
        if (sh > 64) begin
            q  = 64'd0;
            g  = 1'b0;
            st = 1'b1;
        end else if (sh > 0) begin
            q    = n >> sh;
            g    = n[sh-1];
            mask = (64'd1 << (sh - 1)) - 64'd1;
            st   = |(n & mask);
        end else begin
            q  = n << (-sh);
            g  = 1'b0;
            st = 1'b0;
        end
        q = q + {63'd0, g & (st | q[0])};
        if (q[24]) begin
            q  = q >> 1;
            sh = sh + 1;
        end
        fe = q[23] ? sh + x + 150 : 0;
        if (fe >= 255) return {s, PINF[30:0]};
        return {s, fe[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] fsq(input logic [31:0] a);
        logic [7:0]  e;
        logic [23:0] m;
        logic [63:0] p;
        int          ex;
        e = a[30:23];
        if (e == 8'hFF) return (a[22:0] != 23'd0) ? QNAN : PINF;
        m  = {e != 8'd0, a[22:0]};
        ex = (e == 8'd0) ? 1 : int'(e);
        p  = {40'd0, m} * {40'd0, m};
        return round_pack(1'b0, p, 2 * ex - 300);
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [63:0] na;
        logic [63:0] nb;
        logic [63:0] nr;
        logic [63:0] sb;
        logic        st;
        logic        sr;
        int          eh;
        int          el;
        int          d;
        if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) ||
            (b[30:23] == 8'hFF && b[22:0] != 23'd0)) return QNAN;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
            return (a[31] != b[31]) ? QNAN : a;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:23] == 8'hFF) return b;
        if (a[30:23] >= b[30:23]) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        eh = (hi[30:23] == 8'd0) ? 1 : int'(hi[30:23]);
        el = (lo[30:23] == 8'd0) ? 1 : int'(lo[30:23]);
        d  = eh - el;
        na = {37'd0, hi[30:23] != 8'd0, hi[22:0], 3'd0};
        sb = {37'd0, lo[30:23] != 8'd0, lo[22:0], 3'd0};
        if (d >= 27) begin
            nb = {63'd0, sb != 64'd0};
        end else begin
            st = |(sb & ((64'd1 << d) - 64'd1));
            nb = (sb >> d) | {63'd0, st};
        end
        if (hi[31] == lo[31]) begin
            nr = na + nb;
            sr = hi[31];
        end else if (na >= nb) begin
            nr = na - nb;
            sr = hi[31];
        end else begin
            nr = nb - na;
            sr = lo[31];
        end
        if (nr == 64'd0) return {a[31] & b[31], 31'd0};
        return round_pack(sr, nr, eh - 153);
    endfunction

endpackage

// File: rtl/spsn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsn_front
// Accepts requests, tags site close / vector end, and queues them.
// ----------------------------------------------------------------------------
module spsn_front
    import spsn_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0][31:0] re,
    input  logic [2:0][31:0] im,
    input  logic [1:0]       spin_index,
    input  logic             last_site,
    output head_t            head,
    input  logic             pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t               mem_reg [DEPTH];
    logic [PW-1:0]       wr_reg;
    logic [PW-1:0]       wr_next;
    logic [PW-1:0]       rd_reg;
    logic [PW-1:0]       rd_next;
    logic [PW:0]         cnt_reg;
    logic [PW:0]         cnt_next;
    logic                push;
    item_t               in_item;

    assign in_ready = (cnt_reg != (PW+1)'(DEPTH));
    assign push     = in_valid & in_ready;

    always_comb
    begin
        in_item.re         = re;
        in_item.im         = im;
        in_item.close_site = (spin_index == 2'd3);
        in_item.last       = (spin_index == 2'd3) & last_site;
    end

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push & ~pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop & ~push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_reg];

endmodule

// File: rtl/spsn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsn_back
// Step sequencer over one squaring unit and one binary32 adder.
// ----------------------------------------------------------------------------
module spsn_back
    import spsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  head_t       head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] norm
);

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic [31:0] m_reg;
    logic [31:0] t_reg;
    logic [31:0] acc_reg;
    logic [31:0] rs_reg;
    logic [31:0] cmp_reg;
    logic [31:0] tr_reg;
    logic [31:0] ts_reg;
    logic [31:0] norm_reg;
    logic        out_valid_reg;
    logic        run;
    logic        out_free;
    logic [1:0]  mul_sel;
    logic [31:0] mul_in;
    logic [31:0] mul_out;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_y;
    logic        fin;

    assign out_free = ~out_valid_reg | out_ready;
    assign run      = head.valid & ((step_reg != STEP_EMIT) | out_free);

    // steps 6 and 7 square nothing that is used; keep the index in range
    always_comb
    begin
        mul_sel = (step_reg[2:1] == 2'd3) ? 2'd2 : step_reg[2:1];
        mul_in  = step_reg[0] ? head.item.im[mul_sel] : head.item.re[mul_sel];
        mul_out = fsq(mul_in);
    end

    always_comb
    begin
        add_a = t_reg;
        add_b = m_reg;
        case (step_reg)
            4'd3, 4'd5, 4'd7:
            begin
                add_a = acc_reg;
                add_b = t_reg;
            end
            4'd8:
            begin
                add_a = acc_reg;
                add_b = cmp_reg;
            end
            4'd9:
            begin
                add_a = tr_reg;
                add_b = rs_reg;
            end
            4'd10:
            begin
                add_a = ts_reg;
                add_b = {~rs_reg[31], rs_reg[30:0]};
            end
            4'd11:
            begin
                add_a = tr_reg;
                add_b = {~t_reg[31], t_reg[30:0]};
            end
            4'd12:
            begin
                add_a = rs_reg;
                add_b = cmp_reg;
            end
            default:
            begin
                add_a = t_reg;
                add_b = m_reg;
            end
        endcase
        add_y = fadd(add_a, add_b);
    end

    always_comb
    begin
        fin = 1'b0;
        if (step_reg == STEP_OPEN_END && !head.item.close_site) fin = 1'b1;
        if (step_reg == STEP_CLOSE_END && !head.item.last)      fin = 1'b1;
        if (step_reg == STEP_EMIT)                               fin = 1'b1;
        pop       = run & fin;
        step_next = fin ? 4'd0 : step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            rs_reg        <= '0;
            cmp_reg       <= '0;
        end
        else
        begin
            if (run && step_reg == STEP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (run)
            begin
                step_reg <= step_next;
                case (step_reg)
                    4'd3, 4'd5, 4'd7: acc_reg <= add_y;
                    4'd10:            rs_reg  <= ts_reg;
                    4'd11:
                    begin
                        cmp_reg <= add_y;
                        acc_reg <= '0;
                    end
                    4'd12:
                    begin
                        rs_reg  <= '0;
                        cmp_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            m_reg <= mul_out;
            case (step_reg)
                4'd1, 4'd3, 4'd5: t_reg <= m_reg;
                4'd2, 4'd4, 4'd6: t_reg <= add_y;
                4'd8:             tr_reg <= add_y;
                4'd9:             ts_reg <= add_y;
                4'd10:            t_reg <= add_y;
                4'd12:            norm_reg <= add_y;
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign norm      = norm_reg;

endmodule

// File: rtl/spinor_square_norm_kahan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spinor_square_norm_kahan
// Streaming Kahan-compensated binary32 squared norm of a spinor vector.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one spin component of a site per request,
// three complex binary32 values plus spin_index and last_site. spin_index 3
// closes the site; last_site on that request ends the vector.
// Output channel (out_valid/out_ready): one norm per vector, in binary32 bits.
// Requests land in a 2-entry queue; the back end walks each one through one
// squaring unit and one adder, a step per cycle while a request is queued:
//   site-open request  : squares its six values into the site sum
//   site-closing       : also folds the site sum into the Kahan sum
//   vector-ending      : also adds in the compensation and registers the norm
// Sharing the two units sets the pace. Queue and output register let input keep
// flowing while a norm waits; if out_ready stays low the back end holds on
// its final step and the queue then fills and drops in_ready.
// Reset clears queue, sums and compensation to +0 and drops out_valid.
// ----------------------------------------------------------------------------
module spinor_square_norm_kahan
    import spsn_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] c0_re,
    input  logic [31:0] c0_im,
    input  logic [31:0] c1_re,
    input  logic [31:0] c1_im,
    input  logic [31:0] c2_re,
    input  logic [31:0] c2_im,
    input  logic [1:0]  spin_index,
    input  logic        last_site,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] norm
);

    head_t            head;
    logic             pop;
    logic [2:0][31:0] re;
    logic [2:0][31:0] im;

    assign re = {c2_re, c1_re, c0_re};
    assign im = {c2_im, c1_im, c0_im};

    spsn_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .re         (re),
        .im         (im),
        .spin_index (spin_index),
        .last_site  (last_site),
        .head       (head),
        .pop        (pop)
    );

    spsn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .norm      (norm)
    );

endmodule
